// File: rtl/core/bsk_pkg.sv
// Shared constants and record type for the sort-by-key block.
`timescale 1ns / 1ps

package bsk_pkg;

   // Record store capacity
   localparam int DEPTH = 16;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   // Field widths
   localparam int KEY_W = 24;
   localparam int TAG_W = 8;
   localparam int REC_W = KEY_W + TAG_W;

   // One stored record: key in the low bits, tag above it
   typedef struct packed {
      logic [TAG_W-1:0] tag;
      logic [KEY_W-1:0] key;
   } rec_type;

endpackage

// File: rtl/core/bubble_sort_by_key.sv
// Top level of the sort-by-key block: record load, bubble sort sequencer, sorted output.
`timescale 1ns / 1ps

// Collects records (24-bit key, 8-bit tag) one per cycle into a 16-entry RAM
// until an item with tlast arrives, then sorts them in ascending key order,
// stable for equal keys, and sends them out with tlast on the final one and
// tuser set on every one if records beyond capacity were dropped from that
// set. req_tready is low from the last record until the final sorted item has
// been handed to the output register. The sort makes n-1 passes for n
// records; each pass fetches the first record, then one RAM read and one
// RAM write a cycle feed a single key comparator that carries the larger
// record along, and the pass ends by parking the carried record at the top
// of the range. Output reads each record from the RAM and then loads it into
// the output register.
module bubble_sort_by_key
   import bsk_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Input records
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [23:0] price_key, [31:24] record_tag
   input  logic        req_tlast,   // last_record
   // Sorted records
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [23:0] sorted_key, [31:24] sorted_tag
   output logic        rsp_tlast,   // final_out
   output logic        rsp_tuser    // overflowed
);

   typedef enum logic [6:0] {
      S_LOAD   = 7'b0000001,
      S_PSTART = 7'b0000010,
      S_PFIRST = 7'b0000100,
      S_PRUN   = 7'b0001000,
      S_PEND   = 7'b0010000,
      S_ORD    = 7'b0100000,
      S_OLD    = 7'b1000000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             drop_ff, drop_in;
   logic [IDX_W-1:0] lim_ff, lim_in;
   logic [IDX_W-1:0] pos_ff, pos_in;
   logic [IDX_W-1:0] oidx_ff, oidx_in;
   rec_type          carry_ff, carry_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rec_type          rsp_rec_ff, rsp_rec_in;
   logic             rsp_last_ff, rsp_last_in;
   logic             rsp_ovf_ff, rsp_ovf_in;

   // RAM port signals
   logic             ram_we;
   logic [IDX_W-1:0] ram_waddr;
   rec_type          ram_wdata;
   logic             ram_re;
   logic [IDX_W-1:0] ram_raddr;
   logic [REC_W-1:0] ram_rdata;
   rec_type          rd_rec;

   // Helpers
   logic             req_acc;
   logic             has_room;
   logic [CNT_W-1:0] cnt_new;
   logic [IDX_W-1:0] pos_inc;
   logic [IDX_W-1:0] last_idx;

   assign rd_rec   = rec_type'(ram_rdata);
   assign req_acc  = req_tvalid && req_tready;
   assign has_room = count_ff < CNT_W'(DEPTH);
   assign cnt_new  = has_room ? CNT_W'(count_ff + 1'b1) : count_ff;
   assign pos_inc  = IDX_W'(pos_ff + 1'b1);
   assign last_idx = IDX_W'(count_ff - 1'b1);

   bsk_ram #(
      .WIDTH (REC_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Sequencer: load, compare-and-carry passes, readout
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      drop_in      = drop_ff;
      lim_in       = lim_ff;
      pos_in       = pos_ff;
      oidx_in      = oidx_ff;
      carry_in     = carry_ff;
      rsp_rec_in   = rsp_rec_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      ram_we       = 1'b0;
      ram_waddr    = pos_ff;
      ram_wdata    = carry_ff;
      ram_re       = 1'b0;
      ram_raddr    = '0;

      case (state_ff)
         S_LOAD: begin
            // Store the item if there is room, else flag the drop
            ram_waddr = IDX_W'(count_ff);
            ram_wdata = rec_type'(req_tdata[REC_W-1:0]);
            if (req_acc) begin
               ram_we   = has_room;
               count_in = cnt_new;
               if (!has_room) begin
                  drop_in = 1'b1;
               end
               if (req_tlast) begin
                  oidx_in = '0;
                  lim_in  = IDX_W'(cnt_new - 1'b1);
                  if (cnt_new >= CNT_W'(2)) begin
                     state_in = S_PSTART;
                  end else begin
                     state_in = S_ORD;
                  end
               end
            end
         end
         S_PSTART: begin
            // Fetch the first record of the pass
            ram_re    = 1'b1;
            ram_raddr = '0;
            state_in  = S_PFIRST;
         end
         S_PFIRST: begin
            // Take it as the carried record, fetch its neighbor
            carry_in  = rd_rec;
            pos_in    = '0;
            ram_re    = 1'b1;
            ram_raddr = IDX_W'(1);
            state_in  = S_PRUN;
         end
         S_PRUN: begin
            // Write back the smaller, carry the larger (swap only on greater)
            ram_we    = 1'b1;
            ram_waddr = pos_ff;
            if (carry_ff.key > rd_rec.key) begin
               ram_wdata = rd_rec;
            end else begin
               ram_wdata = carry_ff;
               carry_in  = rd_rec;
            end
            pos_in = pos_inc;
            if (pos_inc == lim_ff) begin
               state_in = S_PEND;
            end else begin
               ram_re    = 1'b1;
               ram_raddr = IDX_W'(pos_ff + 2'd2);
            end
         end
         S_PEND: begin
            // Park the largest record at the end of the pass
            ram_we    = 1'b1;
            ram_waddr = lim_ff;
            ram_wdata = carry_ff;
            if (lim_ff == IDX_W'(1)) begin
               state_in = S_ORD;
            end else begin
               lim_in   = IDX_W'(lim_ff - 1'b1);
               state_in = S_PSTART;
            end
         end
         S_ORD: begin
            // Fetch the next sorted record
            ram_re    = 1'b1;
            ram_raddr = oidx_ff;
            state_in  = S_OLD;
         end
         S_OLD: begin
            // Load the output register once it is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_rec_in   = rd_rec;
               rsp_last_in  = (oidx_ff == last_idx);
               rsp_ovf_in   = drop_ff;
               if (oidx_ff == last_idx) begin
                  count_in = '0;
                  drop_in  = 1'b0;
                  state_in = S_LOAD;
               end else begin
                  oidx_in  = IDX_W'(oidx_ff + 1'b1);
                  state_in = S_ORD;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         count_ff     <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      lim_ff      <= lim_in;
      pos_ff      <= pos_in;
      oidx_ff     <= oidx_in;
      carry_ff    <= carry_in;
      rsp_rec_ff  <= rsp_rec_in;
      rsp_last_ff <= rsp_last_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   assign req_tready = (state_ff == S_LOAD);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_rec_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_ovf_ff;

endmodule

// File: rtl/core/bsk_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module bsk_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read, held while idle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sim/bubble_sort_by_key_tb.sv
// Self-checking testbench for bubble_sort_by_key: random record sets, stalls, sorted-run checks.
`timescale 1ns / 1ps

module bubble_sort_by_key_tb;
   import bsk_pkg::*;

   localparam int CLK_PERIOD  = 12;
   localparam int ITEM_TARGET = 370;
   localparam int SETTLE      = 400;

   // One sorted record as it should leave the block
   typedef struct {
      rec_type rec;
      bit      final_flag;
      bit      ovf_flag;
   } sorted_entry_type;

   // Tracks the record set being loaded and the sorted runs still owed
   class sorted_run_tracker_type;
      rec_type          held [DEPTH];
      int               held_count;
      bit               dropped;
      sorted_entry_type sorted_due [$];
      int               errors;

      function new();
         held_count = 0;
         dropped    = 0;
         errors     = 0;
      endfunction

      function int pending();
         return sorted_due.size();
      endfunction

      // Store or drop one accepted record; on the closing record queue the sorted run
      function void note_record(rec_type r, bit closes);
         rec_type          run [$];
         rec_type          tmp;
         sorted_entry_type e;
         int               i;
         int               j;
         if (held_count < DEPTH) begin
            held[held_count] = r;
            held_count++;
         end else begin
            dropped = 1'b1;
         end
         if (!closes) return;
         // Stable insertion: move a record left only past strictly greater keys
         for (i = 0; i < held_count; i++) begin
            run.push_back(held[i]);
            j = run.size() - 1;
            while (j > 0 && run[j-1].key > run[j].key) begin
               tmp      = run[j-1];
               run[j-1] = run[j];
               run[j]   = tmp;
               j--;
            end
         end
         for (i = 0; i < run.size(); i++) begin
            e.rec        = run[i];
            e.final_flag = (i == run.size() - 1);
            e.ovf_flag   = dropped;
            sorted_due.push_back(e);
         end
         held_count = 0;
         dropped    = 1'b0;
      endfunction

      task report(string msg);
         $display("ERROR at %0t ns: %s", $time, msg);
         errors++;
      endtask

      // Compare one accepted sorted item with the oldest one owed
      task check_sorted(logic [31:0] data, logic fin, logic ovf);
         sorted_entry_type e;
         rec_type          got;
         got = data;
         if (sorted_due.size() == 0) begin
            report($sformatf("unexpected item key=%h tag=%h", got.key, got.tag));
         end else begin
            e = sorted_due.pop_front();
            if (got.key !== e.rec.key)
               report($sformatf("key %h, want %h", got.key, e.rec.key));
            if (got.tag !== e.rec.tag)
               report($sformatf("tag %h, want %h (key %h)", got.tag, e.rec.tag, e.rec.key));
            if (fin !== e.final_flag)
               report($sformatf("tlast %b, want %b (key %h)", fin, e.final_flag, e.rec.key));
            if (ovf !== e.ovf_flag)
               report($sformatf("tuser %b, want %b (key %h)", ovf, e.ovf_flag, e.rec.key));
         end
      endtask
   endclass

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;

   sorted_run_tracker_type sort_track = new();
   bit                     req_steady = 1'b0;

   bubble_sort_by_key u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // Mostly short idle stretches, now and then a long one
   function int idle_len();
      if ($urandom_range(0, 9) == 0) return $urandom_range(12, 40);
      return $urandom_range(1, 3);
   endfunction

   function int item_gap();
      if (req_steady) return 0;
      if ($urandom_range(0, 99) < 60) return 0;
      return idle_len();
   endfunction

   // Present one record and hold it until accepted, then idle for the gap
   task send_record(rec_type r, bit closes);
      int gap;
      gap = item_gap();
      req_tdata  <= r;
      req_tlast  <= closes;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
      sort_track.note_record(r, closes);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Hold off the sender until every owed sorted item has come out
   task wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sort_track.pending() > 0) @(posedge clock);
   endtask

   // Send one set of random records, the final one closing the set
   task send_random_set(int count);
      rec_type r;
      int      key_mode;
      int      i;
      key_mode   = $urandom_range(0, 2);
      req_steady = ($urandom_range(0, 3) == 0);
      for (i = 0; i < count; i++) begin
         case (key_mode)
            0: r.key = 24'($urandom);
            1: r.key = 24'($urandom_range(0, 7));
            default: r.key = 24'(24'hFFFFFF - $urandom_range(0, 7));
         endcase
         r.tag = 8'($urandom);
         send_record(r, i == count - 1);
      end
   endtask

   // Accept sorted items with random stalls and check each one
   initial begin : rsp_side
      int stall_left;
      int beats;
      bit steady;
      stall_left = 0;
      beats      = 0;
      steady     = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp_tvalid === 1'b1 && rsp_tready)
            sort_track.check_sorted(rsp_tdata, rsp_tlast, rsp_tuser);
         beats++;
         if (beats % 200 == 0) steady = ($urandom_range(0, 2) == 0);
         if (steady) begin
            rsp_tready <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            stall_left = idle_len() - 1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Directed sets, then random sets, then drain and judge
   initial begin : req_side
      rec_type r;
      int      sent;
      int      count;
      int      pick;
      int      i;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Single record at the top of both fields, then at the bottom
      r.key = 24'hFFFFFF;
      r.tag = 8'hFF;
      send_record(r, 1'b1);
      r.key = 24'h000000;
      r.tag = 8'h00;
      send_record(r, 1'b1);

      // Equal keys must keep arrival order
      for (i = 0; i < 4; i++) begin
         r.key = (i % 2 == 0) ? 24'd5 : 24'd3;
         r.tag = 8'(i + 1);
         send_record(r, i == 3);
      end

      // Full store in descending order plus a closing record that gets dropped
      for (i = 0; i <= DEPTH; i++) begin
         r.key = (i == DEPTH) ? 24'd0 : 24'((DEPTH - i) * 24'h0F0001);
         r.tag = 8'(8'h80 | i);
         send_record(r, i == DEPTH);
      end
      wait_drained();

      sent = 0;
      while (sent < ITEM_TARGET) begin
         pick = $urandom_range(0, 99);
         if (pick < 15)      count = $urandom_range(1, 3);
         else if (pick < 85) count = $urandom_range(4, DEPTH);
         else                count = $urandom_range(DEPTH + 1, DEPTH + 4);
         send_random_set(count);
         sent += count;
         if ($urandom_range(0, 5) == 0) wait_drained();
      end

      req_tvalid <= 1'b0;
      while (sort_track.pending() > 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (sort_track.errors == 0 && sort_track.pending() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Stop a hung run
   initial begin : watchdog
      #(CLK_PERIOD * 600000);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
